// ===== design/button_edge_hold_repeat_unit_macros.svh =====
// Assertion macros shared by the button edge, hold and repeat block.
`ifndef BUTTON_EDGE_HOLD_REPEAT_UNIT_MACROS_SVH
`define BUTTON_EDGE_HOLD_REPEAT_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BEHR_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the trigger.
`define BEHR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/behr_pkg.sv =====
// Shared types and constants for the button edge, hold and repeat block.
`default_nettype none

package behr_pkg;

   localparam int MASK_W          = 8;
   localparam int TICK_W          = 10;
   localparam int HOLD_W          = 16;
   localparam int PERIOD_W        = 10;
   localparam int ACC_W           = 11;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int RSP_DATA_W      = 5 * MASK_W;
   localparam int NUM_BUTTONS_DEF = 8;

   localparam logic [TICK_W-1:0]   TICK_RESET      = TICK_W'(10);
   localparam logic [HOLD_W-1:0]   THRESHOLD_RESET = HOLD_W'(1000);
   localparam logic [HOLD_W-1:0]   DELAY_RESET     = HOLD_W'(500);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(100);

   localparam logic [1:0] REG_TICK      = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_DELAY     = 2'd2;
   localparam logic [1:0] REG_PERIOD    = 2'd3;

   typedef struct packed {
      logic [TICK_W-1:0]   tick_ms;
      logic [HOLD_W-1:0]   hold_threshold_ms;
      logic [HOLD_W-1:0]   repeat_delay_ms;
      logic [PERIOD_W-1:0] repeat_period_ms;
   } cfg_type;

   typedef struct packed {
      logic level;
      logic pressed;
      logic released;
      logic held;
      logic repeat_pulse;
   } lane_out_type;

endpackage

`default_nettype wire

// ===== design/behr_lane.sv =====
// One button lane: level, hold-time counter and auto-repeat accumulator.
`default_nettype none

module behr_lane
   import behr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         accept,
   input  wire logic         cur,
   output lane_out_type      result
);

   logic              level_ff, level_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   logic [HOLD_W:0]   hold_sum;
   logic [ACC_W:0]    acc_sum;
   logic              prev;

   assign prev     = level_ff;
   assign hold_sum = {1'b0, hold_ff} + (HOLD_W + 1)'(cfg.tick_ms);
   assign acc_sum  = {1'b0, acc_ff} + (ACC_W + 1)'(cfg.tick_ms);

   always_comb begin
      level_in = cur;
      if (cur != prev) begin
         hold_in = '0;
      end else if (hold_sum[HOLD_W]) begin
         hold_in = '1;
      end else begin
         hold_in = hold_sum[HOLD_W-1:0];
      end

      result.level        = cur;
      result.pressed      = cur && !prev;
      result.released     = !cur && prev;
      result.held         = cur && (hold_in >= cfg.hold_threshold_ms);
      result.repeat_pulse = 1'b0;
      acc_in              = acc_ff;

      // Before the delay only the press edge pulses; after it the accumulator paces pulses.
      if (cur) begin
         if (hold_in < cfg.repeat_delay_ms) begin
            result.repeat_pulse = !prev;
         end else begin
            result.repeat_pulse = (acc_ff == '0);
            if (acc_sum >= (ACC_W + 1)'(cfg.repeat_period_ms)) begin
               acc_in = '0;
            end else begin
               acc_in = acc_sum[ACC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         hold_ff  <= '0;
         acc_ff   <= '0;
      end else if (accept) begin
         level_ff <= level_in;
         hold_ff  <= hold_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/behr_merge.sv =====
// Merges the lane results into the five masks and holds the output register.
`default_nettype none

module behr_merge
   import behr_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lane_out_type          lanes [NUM_BUTTONS],
   input  wire logic                  accept,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       can_take
);

   logic [MASK_W-1:0] cur_mask, press_mask, rel_mask, held_mask, rep_mask;
   logic [RSP_DATA_W-1:0] data_ff;
   logic                  valid_ff;

   // Button numbers beyond the lane count read as zero.
   for (genvar i = 0; i < MASK_W; i++) begin : g_bit
      if (i < NUM_BUTTONS) begin : g_on
         assign cur_mask[i]   = lanes[i].level;
         assign press_mask[i] = lanes[i].pressed;
         assign rel_mask[i]   = lanes[i].released;
         assign held_mask[i]  = lanes[i].held;
         assign rep_mask[i]   = lanes[i].repeat_pulse;
      end else begin : g_off
         assign cur_mask[i]   = 1'b0;
         assign press_mask[i] = 1'b0;
         assign rel_mask[i]   = 1'b0;
         assign held_mask[i]  = 1'b0;
         assign rep_mask[i]   = 1'b0;
      end
   end

   assign can_take   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= {rep_mask, held_mask, rel_mask, press_mask, cur_mask};
      end
   end

endmodule

`default_nettype wire

// ===== design/button_edge_hold_repeat_unit.sv =====
// Top level of the button edge, hold and auto-repeat detector.
//
// Each beat on the req_ channel is one tick and carries the raw button levels.
// Every tick produces exactly one beat on the rsp_ channel with the new levels
// and the press, release, held and auto-repeat masks for that tick.
// One lane per button updates its level, hold counter and repeat accumulator
// in the cycle the request beat is accepted; the merge stage registers the
// masks, so a result appears in the cycle after its request is accepted.
// Throughput is one tick per cycle: req_tready stays high while the result
// register is empty or being drained, so a stalled receiver stops the input
// only once a finished result is waiting.
// The user must write timing parameters through the csr_ port only while no
// tick is in flight; the block does not enforce it. Registers sit at byte
// offsets 0, 4, 8 and 12. Reset clears all button state and loads the default
// tick, threshold, delay and period values; no result is pending afterwards.
`default_nettype none

`include "button_edge_hold_repeat_unit_macros.svh"

module button_edge_hold_repeat_unit
   import behr_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [MASK_W-1:0]      req_tdata,   // buttons [7:0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // current_mask [7:0], pressed_mask [15:8], released_mask [23:16],
   // held_mask [31:24], repeat_mask [39:32]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   cfg_type      cfg_ff;
   lane_out_type lanes [NUM_BUTTONS];
   logic         req_accept;
   logic         can_take;
   logic         csr_write;
   logic [1:0]   csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms           <= TICK_RESET;
         cfg_ff.hold_threshold_ms <= THRESHOLD_RESET;
         cfg_ff.repeat_delay_ms   <= DELAY_RESET;
         cfg_ff.repeat_period_ms  <= PERIOD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_TICK:      cfg_ff.tick_ms           <= csr_pwdata[TICK_W-1:0];
            REG_THRESHOLD: cfg_ff.hold_threshold_ms <= csr_pwdata[HOLD_W-1:0];
            REG_DELAY:     cfg_ff.repeat_delay_ms   <= csr_pwdata[HOLD_W-1:0];
            REG_PERIOD:    cfg_ff.repeat_period_ms  <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TICK:      csr_prdata = CSR_DATA_W'(cfg_ff.tick_ms);
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.hold_threshold_ms);
         REG_DELAY:     csr_prdata = CSR_DATA_W'(cfg_ff.repeat_delay_ms);
         REG_PERIOD:    csr_prdata = CSR_DATA_W'(cfg_ff.repeat_period_ms);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_tready = can_take;
   assign req_accept = req_tvalid && req_tready;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic cur;
      // Buttons past the input width have no level bit and stay up.
      if (i < MASK_W) begin : g_in
         assign cur = req_tdata[i];
      end else begin : g_up
         assign cur = 1'b0;
      end

      behr_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg_ff),
         .accept (req_accept),
         .cur    (cur),
         .result (lanes[i])
      );
   end

   behr_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .lanes      (lanes),
      .accept     (req_accept),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .can_take   (can_take)
   );

   `BEHR_ASSERT_NEXT(a_result_follows, req_accept, rsp_tvalid && (rsp_tdata[7:0] == $past(req_tdata)), "result beat missing or level mask wrong")
   `BEHR_ASSERT_NOW(a_edges_disjoint, !rsp_tvalid || ((rsp_tdata[15:8] & rsp_tdata[23:16]) == '0), "press and release on one button")
   `BEHR_ASSERT_NOW(a_masks_need_level, !rsp_tvalid || (((rsp_tdata[15:8] | rsp_tdata[31:24] | rsp_tdata[39:32]) & ~rsp_tdata[7:0]) == '0), "press, held or repeat on a button that is up")
   `BEHR_ASSERT_NOW(a_ready_when_empty, rsp_tvalid || req_tready, "input stalled with empty result register")

endmodule

`default_nettype wire
